>>> rtl/gmac_pkg.sv
// Package for the GEMM multiply-accumulate block: sizes, command and register
// codes, the inner-product control word and address helpers.
// No dependencies.
`default_nettype none

package gmac_pkg;

  localparam int MAX_DIM     = 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W       = $clog2(MAX_DIM + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CMD_W      = 2;
  localparam int POS_W      = 3;
  localparam int AB_W       = 16;
  localparam int C_W        = 32;
  localparam int SCALE_W    = 16;
  localparam int CFG_DIM_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int PROD_W = 2 * AB_W;
  localparam int SUM_W  = PROD_W + $clog2(MAX_DIM);
  localparam int AS_W   = SCALE_W + SUM_W;
  localparam int BC_W   = SCALE_W + C_W;
  localparam int ACC_W  = ((AS_W > BC_W) ? AS_W : BC_W) + 1;

  localparam logic [C_W-1:0] SAT_MAX = {1'b0, {(C_W-1){1'b1}}};
  localparam logic [C_W-1:0] SAT_MIN = {1'b1, {(C_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_LOAD_C = 2'd2,
    CMD_START  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_M  = 3'd0,
    CFG_COLS_N  = 3'd1,
    CFG_INNER_K = 3'd2,
    CFG_ALPHA   = 3'd3,
    CFG_BETA    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic clear;
    logic data_vld;
  } dot_ctrl_t;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
    if (int'(d) > MAX_DIM) begin
      return CNT_W'(MAX_DIM);
    end
    return CNT_W'(d);
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage

`default_nettype wire

>>> rtl/gemm_multiply_accumulate.sv
// GEMM multiply-accumulate, C = beta*C + alpha*A*B, top level.
// Depends on gmac_pkg and gmac_dot_acc.
//
// Usage: the input channel carries load words (one element of A, B or C,
// addressed by row and column) and start words. Loads are taken one per
// cycle while idle. A start computes every element of the rows_m x cols_n
// result in row-major order and sends each on the output channel with its
// position, the value clipped to signed 32 bits, a clip flag and a last
// marker on the final element; each result is also written back into the C
// store. Per element, the single read port of the A and B stores gives one
// product per cycle, followed by the multiply, accumulate, scale and clip
// stages. No new word is taken until the last result has entered the output
// register. The config port is always ready.
// Reset restores rows_m = cols_n = inner_k = 8, alpha = 1, beta = 0; the
// stores keep their contents. When the receiver stalls, the output register
// holds its word and the computation waits in its final stage.
`default_nettype none

module gemm_multiply_accumulate (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  // input channel
  input  wire                                        in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [gmac_pkg::CMD_W-1:0]            command_i,
  input  wire logic [gmac_pkg::POS_W-1:0]            row_i,
  input  wire logic [gmac_pkg::POS_W-1:0]            col_i,
  input  wire logic signed [gmac_pkg::AB_W-1:0]      ab_value_i,
  input  wire logic signed [gmac_pkg::C_W-1:0]       c_value_i,
  // configuration channel
  input  wire                                        cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [gmac_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [gmac_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // output channel
  output logic                                       out_valid_o,
  input  wire                                        out_ready_i,
  output logic [gmac_pkg::POS_W-1:0]                 out_row_o,
  output logic [gmac_pkg::POS_W-1:0]                 out_col_o,
  output logic signed [gmac_pkg::C_W-1:0]            out_value_o,
  output logic                                       saturated_o,
  output logic                                       last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCALE,
    ST_WRITE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [gmac_pkg::CFG_DIM_W-1:0]     rows_m_q, cols_n_q, inner_k_q;
  logic signed [gmac_pkg::SCALE_W-1:0] alpha_q, beta_q;

  // run control
  logic [gmac_pkg::DIM_W-1:0] i_q, j_q;
  logic [gmac_pkg::CNT_W-1:0] t_q, m_q, n_q, k_q;
  logic                       rd_vld_q;

  // output register
  logic                          out_vld_q;
  logic [gmac_pkg::POS_W-1:0]    out_row_q, out_col_q;
  logic [gmac_pkg::C_W-1:0]      out_value_q;
  logic                          out_sat_q, out_last_q;

  // stores
  logic [gmac_pkg::AB_W-1:0] a_mem [gmac_pkg::STORE_DEPTH];
  logic [gmac_pkg::AB_W-1:0] b_mem [gmac_pkg::STORE_DEPTH];
  logic [gmac_pkg::C_W-1:0]  c_mem [gmac_pkg::STORE_DEPTH];

  logic signed [gmac_pkg::AB_W-1:0] a_rdata_q, b_rdata_q;
  logic signed [gmac_pkg::C_W-1:0]  c_rdata_q;

  localparam int C_W_HI = gmac_pkg::C_W - 1;
  logic signed [gmac_pkg::AS_W-1:0]  as_q;
  logic signed [gmac_pkg::BC_W-1:0]  bc_q;
  logic signed [gmac_pkg::ACC_W-1:0] acc;
  logic [gmac_pkg::ACC_W-C_W_HI-1:0] acc_hi;
  logic                              sat;
  logic [gmac_pkg::C_W-1:0]          res;

  gmac_pkg::cmd_e            cmd;
  gmac_pkg::dot_ctrl_t       dot_ctrl;
  logic signed [gmac_pkg::SUM_W-1:0] dot_sum;
  logic                      dot_busy;

  logic                        in_acc, load_ok, a_we, b_we, c_load_we, c_we;
  logic [gmac_pkg::ADDR_W-1:0] load_addr, cur_addr, c_waddr;
  logic [gmac_pkg::C_W-1:0]    c_wdata;
  logic [gmac_pkg::CNT_W-1:0]  start_m, start_n, start_k;
  logic                        start_go, rd_issue, mac_done, out_free, wr_go;
  logic                        j_last, i_last, last_elem;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cmd         = gmac_pkg::cmd_e'(command_i);

  assign load_ok   = (int'(row_i) < gmac_pkg::MAX_DIM) && (int'(col_i) < gmac_pkg::MAX_DIM);
  assign load_addr = gmac_pkg::elem_addr(row_i[gmac_pkg::DIM_W-1:0],
                                         col_i[gmac_pkg::DIM_W-1:0]);
  assign a_we      = in_acc && load_ok && (cmd == gmac_pkg::CMD_LOAD_A);
  assign b_we      = in_acc && load_ok && (cmd == gmac_pkg::CMD_LOAD_B);
  assign c_load_we = in_acc && load_ok && (cmd == gmac_pkg::CMD_LOAD_C);

  assign start_m  = gmac_pkg::clamp_dim(rows_m_q);
  assign start_n  = gmac_pkg::clamp_dim(cols_n_q);
  assign start_k  = gmac_pkg::clamp_dim(inner_k_q);
  assign start_go = in_acc && (cmd == gmac_pkg::CMD_START) && (start_m != '0) &&
                    (start_n != '0);

  assign rd_issue = (state_q == ST_MAC) && (t_q < k_q);
  assign mac_done = (state_q == ST_MAC) && (t_q == k_q) && !rd_vld_q && !dot_busy;
  assign out_free = !out_vld_q || out_ready_i;
  assign wr_go    = (state_q == ST_WRITE) && out_free;

  assign j_last    = (gmac_pkg::CNT_W'(j_q) == n_q - gmac_pkg::CNT_W'(1));
  assign i_last    = (gmac_pkg::CNT_W'(i_q) == m_q - gmac_pkg::CNT_W'(1));
  assign last_elem = i_last && j_last;

  assign cur_addr = gmac_pkg::elem_addr(i_q, j_q);

  // write-back of a result and C loads never meet: loads come only while idle
  assign c_we    = wr_go || c_load_we;
  assign c_waddr = wr_go ? cur_addr : load_addr;
  assign c_wdata = wr_go ? res : c_value_i;

  // add the scaled terms and clip to 32 bits
  assign acc    = gmac_pkg::ACC_W'(bc_q) + gmac_pkg::ACC_W'(as_q);
  assign acc_hi = acc[gmac_pkg::ACC_W-1:C_W_HI];
  assign sat    = !((&acc_hi) || !(|acc_hi));
  assign res    = sat ? (acc[gmac_pkg::ACC_W-1] ? gmac_pkg::SAT_MIN : gmac_pkg::SAT_MAX)
                      : acc[gmac_pkg::C_W-1:0];

  assign dot_ctrl.clear    = start_go || (wr_go && !last_elem);
  assign dot_ctrl.data_vld = rd_vld_q;

  gmac_dot_acc u_dot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dot_ctrl),
    .a_i    (a_rdata_q),
    .b_i    (b_rdata_q),
    .sum_o  (dot_sum),
    .busy_o (dot_busy)
  );

  // stores: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[load_addr] <= ab_value_i;
    end
    a_rdata_q <= a_mem[gmac_pkg::elem_addr(i_q, t_q[gmac_pkg::DIM_W-1:0])];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[load_addr] <= ab_value_i;
    end
    b_rdata_q <= b_mem[gmac_pkg::elem_addr(t_q[gmac_pkg::DIM_W-1:0], j_q)];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    c_rdata_q <= c_mem[cur_addr];
  end

  // scale stage: both multiplies registered before the final add
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCALE) begin
      as_q <= gmac_pkg::AS_W'(alpha_q) * gmac_pkg::AS_W'(dot_sum);
      bc_q <= gmac_pkg::BC_W'(beta_q) * gmac_pkg::BC_W'(c_rdata_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_m_q    <= gmac_pkg::CFG_DIM_W'(8);
      cols_n_q    <= gmac_pkg::CFG_DIM_W'(8);
      inner_k_q   <= gmac_pkg::CFG_DIM_W'(8);
      alpha_q     <= gmac_pkg::SCALE_W'(1);
      beta_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      t_q         <= '0;
      m_q         <= '0;
      n_q         <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_sat_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (gmac_pkg::cfg_idx_e'(cfg_index_i))
          gmac_pkg::CFG_ROWS_M:  rows_m_q  <= cfg_data_i[gmac_pkg::CFG_DIM_W-1:0];
          gmac_pkg::CFG_COLS_N:  cols_n_q  <= cfg_data_i[gmac_pkg::CFG_DIM_W-1:0];
          gmac_pkg::CFG_INNER_K: inner_k_q <= cfg_data_i[gmac_pkg::CFG_DIM_W-1:0];
          gmac_pkg::CFG_ALPHA:   alpha_q   <= cfg_data_i;
          gmac_pkg::CFG_BETA:    beta_q    <= cfg_data_i;
          default: ;
        endcase
      end

      rd_vld_q <= rd_issue;

      // load the output register on a write-back, else drop the word once taken
      if (wr_go) begin
        out_vld_q   <= 1'b1;
        out_row_q   <= gmac_pkg::POS_W'(i_q);
        out_col_q   <= gmac_pkg::POS_W'(j_q);
        out_value_q <= res;
        out_sat_q   <= sat;
        out_last_q  <= last_elem;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (start_go) begin
            m_q     <= start_m;
            n_q     <= start_n;
            k_q     <= start_k;
            i_q     <= '0;
            j_q     <= '0;
            t_q     <= '0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (rd_issue) begin
            t_q <= t_q + gmac_pkg::CNT_W'(1);
          end
          if (mac_done) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          // hold here while the output register is full and stalled
          if (wr_go) begin
            t_q <= '0;
            if (last_elem) begin
              state_q <= ST_IDLE;
            end else begin
              if (j_last) begin
                j_q <= '0;
                i_q <= i_q + gmac_pkg::DIM_W'(1);
              end else begin
                j_q <= j_q + gmac_pkg::DIM_W'(1);
              end
              state_q <= ST_MAC;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign saturated_o = out_sat_q;
  assign last_o      = out_last_q;

  // the inner product has fully drained before it is scaled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE) |-> (!dot_busy && !rd_vld_q && (t_q == k_q)))
    else $error("scale stage entered before inner product drained");

  // element position stays inside the active dimensions during a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> ((gmac_pkg::CNT_W'(i_q) < m_q) && (gmac_pkg::CNT_W'(j_q) < n_q)))
    else $error("element index outside active dimensions");

  // the word marked last ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_go && last_elem) |=> ((state_q == ST_IDLE) && out_vld_q && out_last_q))
    else $error("last word did not end the run");

endmodule

`default_nettype wire

>>> rtl/gmac_dot_acc.sv
// Inner-product unit: registered 16x16 multiply, then a wide running sum.
// Depends on gmac_pkg.
`default_nettype none

module gmac_dot_acc (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire gmac_pkg::dot_ctrl_t                ctrl_i,
  input  wire logic signed [gmac_pkg::AB_W-1:0]   a_i,
  input  wire logic signed [gmac_pkg::AB_W-1:0]   b_i,
  output logic signed [gmac_pkg::SUM_W-1:0]       sum_o,
  output logic                                    busy_o
);

  logic signed [gmac_pkg::PROD_W-1:0] prod_q;
  logic                               prod_vld_q;
  logic signed [gmac_pkg::SUM_W-1:0]  sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.data_vld) begin
      prod_q <= gmac_pkg::PROD_W'(a_i) * gmac_pkg::PROD_W'(b_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      sum_q      <= '0;
    end else if (ctrl_i.clear) begin
      prod_vld_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.data_vld;
      if (prod_vld_q) begin
        sum_q <= sum_q + gmac_pkg::SUM_W'(prod_q);
      end
    end
  end

  assign sum_o  = sum_q;
  assign busy_o = prod_vld_q;

endmodule

`default_nettype wire
